FILE: design/memory_test_pattern_checker_assert.svh
// Assertion macros for the memory test pattern checker.
`ifndef MEMORY_TEST_PATTERN_CHECKER_ASSERT_SVH
`define MEMORY_TEST_PATTERN_CHECKER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MTPC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("memory test pattern checker: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define MTPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("memory test pattern checker: next-cycle check failed");

`endif

FILE: design/mtpc_pkg.sv
// Types, codes and pattern function for the memory test pattern checker.
`default_nettype none

package mtpc_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int LOG_LIMIT   = 8;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_CHECK = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  localparam logic [3:0] PAT_ZERO       = 4'd0;
  localparam logic [3:0] PAT_ONES       = 4'd1;
  localparam logic [3:0] PAT_55         = 4'd2;
  localparam logic [3:0] PAT_AA         = 4'd3;
  localparam logic [3:0] PAT_CHK_55AA   = 4'd4;
  localparam logic [3:0] PAT_CHK_AA55   = 4'd5;
  localparam logic [3:0] PAT_WALK1_P0   = 4'd6;
  localparam logic [3:0] PAT_WALK1_P1   = 4'd7;
  localparam logic [3:0] PAT_WALK0_P0   = 4'd8;
  localparam logic [3:0] PAT_WALK0_P1   = 4'd9;
  localparam logic [3:0] PAT_ADDR       = 4'd10;
  localparam logic [3:0] PAT_ADDR_INV   = 4'd11;
  localparam logic [3:0] PAT_ADDR_X5A   = 4'd12;
  localparam logic [3:0] PAT_ADDR_XA5   = 4'd13;

  localparam logic [7:0] BYTE_55 = 8'h55;
  localparam logic [7:0] BYTE_AA = 8'hAA;
  localparam logic [7:0] BYTE_5A = 8'h5A;
  localparam logic [7:0] BYTE_A5 = 8'hA5;
  localparam logic [7:0] BYTE_FF = 8'hFF;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] addr;
    logic [7:0]  read_data;
  } in_req_t;

  typedef struct packed {
    logic [7:0]  expected_byte;
    logic        mismatch;
    logic        log_worthy;
    logic [31:0] pattern_errors;
    logic [31:0] total_errors;
  } out_res_t;

  function automatic logic [7:0] walk_one(logic [2:0] bit_pos, logic pass);
    logic [2:0] sh;
    sh = bit_pos + {2'b00, pass};
    return 8'(8'd1 << sh);
  endfunction

  function automatic logic [7:0] pattern_byte(logic [3:0] sel, logic [31:0] addr);
    logic [7:0] lo;
    logic       even;
    logic [7:0] res;
    lo   = addr[7:0];
    even = ~addr[0];
    case (sel)
      PAT_ZERO:     res = 8'h00;
      PAT_ONES:     res = BYTE_FF;
      PAT_55:       res = BYTE_55;
      PAT_AA:       res = BYTE_AA;
      PAT_CHK_55AA: res = even ? BYTE_55 : BYTE_AA;
      PAT_CHK_AA55: res = even ? BYTE_AA : BYTE_55;
      PAT_WALK1_P0: res = walk_one(addr[2:0], 1'b0);
      PAT_WALK1_P1: res = walk_one(addr[2:0], 1'b1);
      PAT_WALK0_P0: res = ~walk_one(addr[2:0], 1'b0);
      PAT_WALK0_P1: res = ~walk_one(addr[2:0], 1'b1);
      PAT_ADDR:     res = lo;
      PAT_ADDR_INV: res = ~lo;
      PAT_ADDR_X5A: res = lo ^ BYTE_5A;
      PAT_ADDR_XA5: res = lo ^ BYTE_A5;
      default:      res = 8'h00;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: design/memory_test_pattern_checker.sv
// Top level of the memory test pattern generator and checker.
//
//  channel | ports                          | payload
//  --------+--------------------------------+----------------------
//  input   | in_valid, in_ready, in_req     | op, addr, read_data
//  result  | out_valid, out_ready, out_res  | expected byte, flags, counts
//  config  | cfg_wr_en, cfg_wr_data         | pattern select
//
// One request per cycle sustained unless the result is stalled; requests
// pass the input register, pattern mux and byte compare, result register.
// The error counters update as a request moves into the result register.
// Synchronous active-low reset clears valids, counters and pattern select.
// A stalled result holds; the input register still fills behind it.
`default_nettype none

module memory_test_pattern_checker (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire mtpc_pkg::in_req_t in_req,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output mtpc_pkg::out_res_t     out_res,
  input  wire logic              cfg_wr_en,
  input  wire logic [3:0]        cfg_wr_data
);
  import mtpc_pkg::*;

  logic                   s1_valid_r;
  in_req_t                s1_req_r;
  logic                   out_valid_r;
  out_res_t               out_res_r;
  out_res_t               res_nxt;
  logic [3:0]             pattern_sel_r;
  logic [COUNT_WIDTH-1:0] pattern_cnt_r;
  logic [COUNT_WIDTH-1:0] pattern_cnt_nxt;
  logic [COUNT_WIDTH-1:0] total_cnt_r;
  logic [COUNT_WIDTH-1:0] total_cnt_nxt;
  logic                   advance;
  logic                   hit;
  logic [7:0]             exp_byte;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  assign exp_byte = pattern_byte(pattern_sel_r, s1_req_r.addr);
  assign hit      = (s1_req_r.op == OP_CHECK) && (s1_req_r.read_data != exp_byte);

  always_comb begin
    pattern_cnt_nxt = pattern_cnt_r;
    total_cnt_nxt   = total_cnt_r;
    if (s1_req_r.op == OP_START) begin
      pattern_cnt_nxt = '0;
    end else if (hit) begin
      if (pattern_cnt_r != '1) begin
        pattern_cnt_nxt = pattern_cnt_r + COUNT_WIDTH'(1);
      end
      if (total_cnt_r != '1) begin
        total_cnt_nxt = total_cnt_r + COUNT_WIDTH'(1);
      end
    end
    res_nxt.expected_byte  = exp_byte;
    res_nxt.mismatch       = hit;
    res_nxt.log_worthy     = hit && (pattern_cnt_r < COUNT_WIDTH'(LOG_LIMIT));
    res_nxt.pattern_errors = 32'(pattern_cnt_nxt);
    res_nxt.total_errors   = 32'(total_cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      pattern_sel_r <= PAT_ZERO;
      pattern_cnt_r <= '0;
      total_cnt_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        pattern_sel_r <= cfg_wr_data;
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r   <= 1'b1;
        pattern_cnt_r <= pattern_cnt_nxt;
        total_cnt_r   <= total_cnt_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_req_r <= in_req;
    end
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

`include "memory_test_pattern_checker_assert.svh"

  `MTPC_ASSERT_NOW(a_log_needs_mismatch, clk, rst_n, out_valid_r && out_res_r.log_worthy, out_res_r.mismatch)
  `MTPC_ASSERT_NOW(a_mismatch_counted, clk, rst_n, out_valid_r && out_res_r.mismatch, out_res_r.total_errors != 32'd0)
  `MTPC_ASSERT_NEXT(a_start_clears, clk, rst_n, advance && (s1_req_r.op == OP_START), pattern_cnt_r == '0)
  `MTPC_ASSERT_NEXT(a_total_monotonic, clk, rst_n, 1'b1, total_cnt_r >= $past(total_cnt_r))
  `MTPC_ASSERT_NOW(a_pattern_le_total, clk, rst_n, 1'b1, pattern_cnt_r <= total_cnt_r)

endmodule

`default_nettype wire
